// File: rtl/ssu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssu_pkg
// Shared types, codes and tables of the stereo to surround upmixer.
// ----------------------------------------------------------------------------
package ssu_pkg;

   localparam int NUM_SPEAKERS = 8;
   localparam int SPK_BITS     = 3;
   localparam int LFE_EXTRA    = 8;

   // 0.70710678 in Q0.32, kept with a zero sign bit
   localparam logic signed [32:0] REAR_GAIN = 33'sd3037000499;

   localparam int LP_GAIN_RESET = 1021;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAYOUT_MODE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LP_GAIN     = 1'd1;

   // layout codes
   localparam int LAYOUT_BITS = 3;
   localparam logic [LAYOUT_BITS-1:0] LAYOUT_STEREO     = 3'd0;
   localparam logic [LAYOUT_BITS-1:0] LAYOUT_QUAD       = 3'd1;
   localparam logic [LAYOUT_BITS-1:0] LAYOUT_FIVE_ONE_B = 3'd2;
   localparam logic [LAYOUT_BITS-1:0] LAYOUT_FIVE_ONE_S = 3'd3;
   localparam logic [LAYOUT_BITS-1:0] LAYOUT_SEVEN_ONE  = 3'd4;

   // speaker codes
   localparam logic [SPK_BITS-1:0] SPK_FL  = 3'd0;
   localparam logic [SPK_BITS-1:0] SPK_FR  = 3'd1;
   localparam logic [SPK_BITS-1:0] SPK_FC  = 3'd2;
   localparam logic [SPK_BITS-1:0] SPK_LFE = 3'd3;
   localparam logic [SPK_BITS-1:0] SPK_BL  = 3'd4;
   localparam logic [SPK_BITS-1:0] SPK_BR  = 3'd5;
   localparam logic [SPK_BITS-1:0] SPK_SL  = 3'd6;
   localparam logic [SPK_BITS-1:0] SPK_SR  = 3'd7;

   // sample slots of one queued frame
   localparam int NUM_SLOTS   = 6;
   localparam int SLOT_LEFT   = 0;
   localparam int SLOT_RIGHT  = 1;
   localparam int SLOT_REAR_L = 2;
   localparam int SLOT_REAR_R = 3;
   localparam int SLOT_CENTRE = 4;
   localparam int SLOT_LFE    = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef logic [NUM_SPEAKERS-1:0] spk_mask_type;

   typedef struct packed {
      spk_mask_type mask;
      logic         last;
   } frame_ctrl_type;

   function automatic spk_mask_type layout_mask(input logic [LAYOUT_BITS-1:0] mode);
      spk_mask_type m;
      case (mode)
         LAYOUT_QUAD:       m = 8'h33;
         LAYOUT_FIVE_ONE_B: m = 8'h3F;
         LAYOUT_FIVE_ONE_S: m = 8'hCF;
         LAYOUT_SEVEN_ONE:  m = 8'hFF;
         default:           m = 8'h03;   // stereo and unused codes
      endcase
      return m;
   endfunction

endpackage

// File: rtl/ssu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssu_queue
// Short frame queue between the front and back ends.
// ----------------------------------------------------------------------------
module ssu_queue
   import ssu_pkg::*;
#(
   parameter int WIDTH = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  frame_ctrl_type   push_ctrl,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output frame_ctrl_type   pop_ctrl
);

   logic [WIDTH-1:0]     data_ff [QUEUE_DEPTH];
   frame_ctrl_type       ctrl_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_data  = data_ff[rd_ptr_ff];
   assign pop_ctrl  = ctrl_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
         ctrl_ff[wr_ptr_ff] <= push_ctrl;
      end
   end

endmodule

// File: rtl/ssu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssu_front
// Takes stereo words, derives centre, rear and LFE samples and the speaker
// mask of the layout, and hands each frame to the queue.
// ----------------------------------------------------------------------------
module ssu_front
   import ssu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEFF_WIDTH  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_left_sample,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_right_sample,
   input  logic                              req_last_frame,
   input  logic [LAYOUT_BITS-1:0]            layout_mode,
   input  logic [COEFF_WIDTH-1:0]            lp_gain,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [NUM_SLOTS*SAMPLE_WIDTH-1:0] q_data,
   output frame_ctrl_type                    q_ctrl
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int LW = SAMPLE_WIDTH + LFE_EXTRA;

   logic                 hold_valid_ff, hold_valid_in;
   logic signed [SW-1:0] left_ff, right_ff;
   logic                 last_ff;
   logic signed [LW-1:0] level_ff, level_in;
   logic                 accept;
   spk_mask_type         mask;

   logic signed [SW:0]               sum;
   logic signed [SW-1:0]             centre;
   logic signed [SW+32:0]            rear_l_prod, rear_r_prod;
   logic signed [LW-1:0]             target;
   logic signed [LW:0]               diff;
   logic signed [LW+COEFF_WIDTH+1:0] lfe_prod;
   logic signed [LW-1:0]             lfe_next;

   assign req_stall = hold_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = hold_valid_ff && !q_full;
   assign mask      = layout_mask(layout_mode);

   always_comb begin
      sum         = {left_ff[SW-1], left_ff} + {right_ff[SW-1], right_ff};
      centre      = sum[SW:1];   // floor of half
      rear_l_prod = left_ff * REAR_GAIN;
      rear_r_prod = right_ff * REAR_GAIN;
      // one-pole low-pass on the widened centre
      target      = {centre, {LFE_EXTRA{1'b0}}};
      diff        = {target[LW-1], target} - {level_ff[LW-1], level_ff};
      lfe_prod    = diff * $signed({1'b0, lp_gain});
      lfe_next    = level_ff + lfe_prod[LW+COEFF_WIDTH-1:COEFF_WIDTH];
   end

   always_comb begin
      hold_valid_in = accept || (hold_valid_ff && !q_push);
      level_in      = level_ff;
      if (q_push && mask[SPK_LFE]) begin
         level_in = lfe_next;
      end
   end

   always_comb begin
      q_data = '0;
      q_data[SLOT_LEFT*SW   +: SW] = left_ff;
      q_data[SLOT_RIGHT*SW  +: SW] = right_ff;
      q_data[SLOT_REAR_L*SW +: SW] = rear_l_prod[SW+31:32];
      q_data[SLOT_REAR_R*SW +: SW] = rear_r_prod[SW+31:32];
      q_data[SLOT_CENTRE*SW +: SW] = centre;
      q_data[SLOT_LFE*SW    +: SW] = lfe_next[LW-1:LFE_EXTRA];
      q_ctrl.mask = mask;
      q_ctrl.last = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         level_ff      <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         level_ff      <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff  <= req_left_sample;
         right_ff <= req_right_sample;
         last_ff  <= req_last_frame;
      end
   end

endmodule

// File: rtl/ssu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssu_back
// Walks the speaker mask of each queued frame and sends one channel word
// per cycle while rsp_stall is low, through the output register.
// ----------------------------------------------------------------------------
module ssu_back
   import ssu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  logic [NUM_SLOTS*SAMPLE_WIDTH-1:0] q_data,
   input  frame_ctrl_type                    q_ctrl,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]    rsp_channel_sample,
   output logic [SPK_BITS-1:0]               rsp_speaker,
   output logic                              rsp_last_in_frame,
   output logic                              rsp_last_of_buffer
);

   localparam int SW = SAMPLE_WIDTH;

   spk_mask_type                 rem_ff, rem_in;
   logic [NUM_SLOTS*SW-1:0]      cur_data_ff;
   logic                         cur_last_ff;
   logic                         out_valid_ff, out_valid_in;
   logic signed [SW-1:0]         out_sample_ff;
   logic [SPK_BITS-1:0]          out_speaker_ff;
   logic                         out_lif_ff, out_lob_ff;

   logic                 busy, out_free, emit, done;
   logic [SPK_BITS-1:0]  sel;
   spk_mask_type         rem_clr;
   logic signed [SW-1:0] value;

   assign busy     = (rem_ff != '0);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = busy && out_free;

   // lowest pending speaker
   always_comb begin
      sel = '0;
      for (int i = NUM_SPEAKERS-1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            sel = SPK_BITS'(i);
         end
      end
      rem_clr = rem_ff & ~(spk_mask_type'(1) << sel);
      done    = (rem_clr == '0);
   end

   // next frame loads as the current one sends its final word
   assign q_pop = q_valid && (!busy || (emit && done));

   always_comb begin
      case (sel)
         SPK_FL:          value = cur_data_ff[SLOT_LEFT*SW   +: SW];
         SPK_FR:          value = cur_data_ff[SLOT_RIGHT*SW  +: SW];
         SPK_FC:          value = cur_data_ff[SLOT_CENTRE*SW +: SW];
         SPK_LFE:         value = cur_data_ff[SLOT_LFE*SW    +: SW];
         SPK_BL, SPK_SL:  value = cur_data_ff[SLOT_REAR_L*SW +: SW];
         SPK_BR, SPK_SR:  value = cur_data_ff[SLOT_REAR_R*SW +: SW];
         default:         value = '0;
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      if (q_pop) begin
         rem_in = q_ctrl.mask;
      end else if (emit) begin
         rem_in = rem_clr;
      end
      out_valid_in = emit || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_data_ff <= q_data;
         cur_last_ff <= q_ctrl.last;
      end
      if (emit) begin
         out_sample_ff  <= value;
         out_speaker_ff <= sel;
         out_lif_ff     <= done;
         out_lob_ff     <= done && cur_last_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_channel_sample = out_sample_ff;
   assign rsp_speaker        = out_speaker_ff;
   assign rsp_last_in_frame  = out_lif_ff;
   assign rsp_last_of_buffer = out_lob_ff;

endmodule

// File: rtl/stereo_surround_upmixer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_surround_upmixer_top
// Stereo to surround upmixer: one stereo frame in, its speaker channels out.
// ----------------------------------------------------------------------------
// Input channel (req_): one word per stereo frame, accepted when req_valid
// is high and req_stall low. Output channel (rsp_): one word per speaker of
// the selected layout in ascending speaker order, accepted when rsp_valid is
// high and rsp_stall low; last_in_frame flags the frame's final channel and
// carries last_of_buffer along with it.
// Config (csr_): csr_ready is always high; index 0 layout_mode, index 1
// LFE low-pass gain. Write only while the block holds no frame.
// A frame passes the front end's hold register, the queue, the back end's
// frame register and the output register before its words show on rsp_.
// They leave one per cycle while rsp_stall is low, one per speaker of the
// layout (2 to 8), set by the back end's single output register. The front
// end and two-frame queue take frames while the back end is busy or stalled.
// A stalled output word holds; the queue fills and req_stall rises.
// Reset clears the LFE filter level, the queue and the output register and
// loads layout stereo and the default LFE coefficient.
// ----------------------------------------------------------------------------
module stereo_surround_upmixer_top
   import ssu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEFF_WIDTH  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_left_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_right_sample,
   input  logic                           req_last_frame,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_channel_sample,
   output logic [SPK_BITS-1:0]            rsp_speaker,
   output logic                           rsp_last_in_frame,
   output logic                           rsp_last_of_buffer,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [COEFF_WIDTH-1:0]         csr_wdata
);

   localparam int DW = NUM_SLOTS * SAMPLE_WIDTH;

   logic [LAYOUT_BITS-1:0] layout_mode_ff, layout_mode_in;
   logic [COEFF_WIDTH-1:0] lp_gain_ff, lp_gain_in;

   logic           q_full, q_push, q_valid, q_pop;
   logic [DW-1:0]  push_data, pop_data;
   frame_ctrl_type push_ctrl, pop_ctrl;

   assign csr_ready = 1'b1;

   always_comb begin
      layout_mode_in = layout_mode_ff;
      lp_gain_in     = lp_gain_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LAYOUT_MODE: layout_mode_in = csr_wdata[LAYOUT_BITS-1:0];
            CSR_LP_GAIN:     lp_gain_in     = csr_wdata;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_mode_ff <= LAYOUT_STEREO;
         lp_gain_ff     <= COEFF_WIDTH'(LP_GAIN_RESET);
      end else begin
         layout_mode_ff <= layout_mode_in;
         lp_gain_ff     <= lp_gain_in;
      end
   end

   ssu_front #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_sample (req_left_sample),
      .req_right_sample(req_right_sample),
      .req_last_frame  (req_last_frame),
      .layout_mode     (layout_mode_ff),
      .lp_gain         (lp_gain_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (push_data),
      .q_ctrl          (push_ctrl)
   );

   ssu_queue #(
      .WIDTH(DW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(push_data),
      .push_ctrl(push_ctrl),
      .full     (q_full),
      .pop_valid(q_valid),
      .pop      (q_pop),
      .pop_data (pop_data),
      .pop_ctrl (pop_ctrl)
   );

   ssu_back #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_data            (pop_data),
      .q_ctrl            (pop_ctrl),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_sample(rsp_channel_sample),
      .rsp_speaker       (rsp_speaker),
      .rsp_last_in_frame (rsp_last_in_frame),
      .rsp_last_of_buffer(rsp_last_of_buffer)
   );

endmodule

// File: rtl/ssu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssu_checker
// Port-level checks of the upmixer's output framing, bound to the top level.
// ----------------------------------------------------------------------------
module ssu_checker
   import ssu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_channel_sample,
   input logic [SPK_BITS-1:0]            rsp_speaker,
   input logic                           rsp_last_in_frame,
   input logic                           rsp_last_of_buffer
);

   logic                in_frame_ff, in_frame_in;
   logic [SPK_BITS-1:0] prev_spk_ff, prev_spk_in;
   logic                rsp_accept;

   assign rsp_accept = rsp_valid && !rsp_stall;

   always_comb begin
      in_frame_in = in_frame_ff;
      prev_spk_in = prev_spk_ff;
      if (rsp_accept) begin
         in_frame_in = !rsp_last_in_frame;
         prev_spk_in = rsp_speaker;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         prev_spk_ff <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         prev_spk_ff <= prev_spk_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel_sample)
         && $stable(rsp_speaker) && $stable(rsp_last_in_frame))
      else $error("output word changed while stalled");

   a_buffer_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_buffer |-> rsp_last_in_frame)
      else $error("buffer end flagged off the frame's final channel");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !in_frame_ff |-> rsp_speaker == SPK_FL)
      else $error("frame does not open with front left");

   a_spk_order: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && in_frame_ff |-> rsp_speaker > prev_spk_ff)
      else $error("speakers out of order within a frame");

endmodule

bind stereo_surround_upmixer_top ssu_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_ssu_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_channel_sample(rsp_channel_sample),
   .rsp_speaker       (rsp_speaker),
   .rsp_last_in_frame (rsp_last_in_frame),
   .rsp_last_of_buffer(rsp_last_of_buffer)
);

// File: sim/upmix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upmix_checker
// Watches the frame, channel and register ports of the upmixer, works out
// every speaker word that an accepted stereo frame must produce and compares
// each accepted channel word, field by field, against the oldest one due.
// ----------------------------------------------------------------------------
module upmix_checker
   import ssu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEFF_WIDTH  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_left_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_right_sample,
   input  logic                           req_last_frame,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] rsp_channel_sample,
   input  logic [SPK_BITS-1:0]            rsp_speaker,
   input  logic                           rsp_last_in_frame,
   input  logic                           rsp_last_of_buffer,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [COEFF_WIDTH-1:0]         csr_wdata,
   output int                             failures,
   output int                             outstanding,
   output int                             words_checked
);

   localparam int REPORT_CAP = 60;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      sample_type          sample;
      logic [SPK_BITS-1:0] speaker;
      logic                last_in_frame;
      logic                last_of_buffer;
   } chan_word_type;

   chan_word_type          due_words[$];
   logic [LAYOUT_BITS-1:0] layout;
   logic [COEFF_WIDTH-1:0] lp_gain;
   longint                 lfe_level;
   int                     reports = 0;

   // floor(d * c / 2^COEFF_WIDTH), coefficient split in two so nothing overflows
   function automatic longint lfe_step(input longint d, input longint c);
      longint hi;
      longint lo;
      hi = d * (c >>> 8);
      lo = d * (c & 255);
      return (hi + (lo >>> 8)) >>> (COEFF_WIDTH - 8);
   endfunction

   function automatic longint rear_scale(input longint x);
      return (x * longint'(REAR_GAIN)) >>> 32;
   endfunction

   // queue every word one stereo frame produces under the current layout
   function automatic void upmix_frame(input sample_type l, input sample_type r,
                                       input logic last);
      logic [NUM_SPEAKERS-1:0] spk_set;
      longint                  level[NUM_SPEAKERS];
      longint                  centre;
      int                      final_spk;
      chan_word_type           w;
      spk_set          = '0;
      spk_set[SPK_FL]  = 1'b1;
      spk_set[SPK_FR]  = 1'b1;
      case (layout)
         LAYOUT_QUAD: begin
            spk_set[SPK_BL] = 1'b1;
            spk_set[SPK_BR] = 1'b1;
         end
         LAYOUT_FIVE_ONE_B: begin
            spk_set[SPK_FC]  = 1'b1;
            spk_set[SPK_LFE] = 1'b1;
            spk_set[SPK_BL]  = 1'b1;
            spk_set[SPK_BR]  = 1'b1;
         end
         LAYOUT_FIVE_ONE_S: begin
            spk_set[SPK_FC]  = 1'b1;
            spk_set[SPK_LFE] = 1'b1;
            spk_set[SPK_SL]  = 1'b1;
            spk_set[SPK_SR]  = 1'b1;
         end
         LAYOUT_SEVEN_ONE: begin
            spk_set = '1;
         end
         default: begin
            // unused codes fall back to stereo
         end
      endcase
      centre          = (longint'(l) + longint'(r)) >>> 1;
      level[SPK_FL]   = l;
      level[SPK_FR]   = r;
      level[SPK_FC]   = centre;
      level[SPK_LFE]  = 0;
      level[SPK_BL]   = rear_scale(l);
      level[SPK_BR]   = rear_scale(r);
      level[SPK_SL]   = level[SPK_BL];
      level[SPK_SR]   = level[SPK_BR];
      // filter only advances on layouts that carry an LFE speaker
      if (spk_set[SPK_LFE]) begin
         lfe_level      = lfe_level + lfe_step((centre <<< LFE_EXTRA) - lfe_level, lp_gain);
         level[SPK_LFE] = lfe_level >>> LFE_EXTRA;
      end
      final_spk = 0;
      for (int s = 0; s < NUM_SPEAKERS; s++) begin
         if (spk_set[s]) final_spk = s;
      end
      for (int s = 0; s < NUM_SPEAKERS; s++) begin
         if (spk_set[s]) begin
            w.sample         = level[s][SAMPLE_WIDTH-1:0];
            w.speaker        = s[SPK_BITS-1:0];
            w.last_in_frame  = (s == final_spk);
            w.last_of_buffer = (s == final_spk) && last;
            due_words.push_back(w);
         end
      end
   endfunction

   task automatic flag(input string what, input longint want, input longint got);
      failures++;
      if (reports < REPORT_CAP) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end else if (reports == REPORT_CAP) begin
         $display("%0t ns: further mismatches not shown", $time);
      end
      reports++;
   endtask

   always @(posedge clock) begin
      chan_word_type want;
      if (reset) begin
         layout    = LAYOUT_STEREO;
         lp_gain   = COEFF_WIDTH'(LP_GAIN_RESET);
         lfe_level = 0;
         due_words.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LAYOUT_MODE) layout = csr_wdata[LAYOUT_BITS-1:0];
            else if (csr_index == CSR_LP_GAIN) lp_gain = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            upmix_frame(req_left_sample, req_right_sample, req_last_frame);
         end
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (due_words.size() == 0) begin
               flag("unexpected word, speaker", -1, rsp_speaker);
            end else begin
               want = due_words.pop_front();
               if (want.sample !== rsp_channel_sample)
                  flag("channel_sample", $signed(want.sample), $signed(rsp_channel_sample));
               if (want.speaker !== rsp_speaker)
                  flag("speaker", want.speaker, rsp_speaker);
               if (want.last_in_frame !== rsp_last_in_frame)
                  flag("last_in_frame", want.last_in_frame, rsp_last_in_frame);
               if (want.last_of_buffer !== rsp_last_of_buffer)
                  flag("last_of_buffer", want.last_of_buffer, rsp_last_of_buffer);
            end
         end
         outstanding <= due_words.size();
      end
   end

endmodule

// File: sim/stereo_surround_upmixer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_surround_upmixer_top_tb
// Drives stereo frames and register writes into the upmixer under random
// idle and stall, first a few edge frames on every layout code, then random
// frames over several layout and LFE coefficient settings; the checker
// beside the block predicts and compares every channel word.
// ----------------------------------------------------------------------------
module stereo_surround_upmixer_top_tb;
   import ssu_pkg::*;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEFF_WIDTH     = 16;
   localparam int RANDOM_PHASES   = 10;
   localparam int FRAMES_PER_PHASE = 32;
   localparam int DRAIN_CYCLES    = 20;
   localparam int CYCLE_LIMIT     = 200000;

   localparam logic [SAMPLE_WIDTH-1:0] EDGE_LEFT [6] =
      '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
   localparam logic [SAMPLE_WIDTH-1:0] EDGE_RIGHT [6] =
      '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

   logic                           clock;
   logic                           reset              = 1'b1;
   logic                           req_valid          = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_left_sample    = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_right_sample   = '0;
   logic                           req_last_frame     = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall          = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_channel_sample;
   logic [SPK_BITS-1:0]            rsp_speaker;
   logic                           rsp_last_in_frame;
   logic                           rsp_last_of_buffer;
   logic                           csr_valid          = 1'b0;
   logic                           csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index          = '0;
   logic [COEFF_WIDTH-1:0]         csr_wdata          = '0;

   int   failures;
   int   outstanding;
   int   words_checked;
   int   cycle_count  = 0;
   int   frames_sent  = 0;
   int   settings_run = 0;
   logic calm         = 1'b0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // output side back-pressure, off during the calm stretch
   always @(posedge clock) rsp_stall <= !calm && ($urandom_range(99) < 32);

   stereo_surround_upmixer_top #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEFF_WIDTH  (COEFF_WIDTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_last_frame     (req_last_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_channel_sample (rsp_channel_sample),
      .rsp_speaker        (rsp_speaker),
      .rsp_last_in_frame  (rsp_last_in_frame),
      .rsp_last_of_buffer (rsp_last_of_buffer),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   upmix_checker #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEFF_WIDTH  (COEFF_WIDTH)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_last_frame     (req_last_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_channel_sample (rsp_channel_sample),
      .rsp_speaker        (rsp_speaker),
      .rsp_last_in_frame  (rsp_last_in_frame),
      .rsp_last_of_buffer (rsp_last_of_buffer),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .failures           (failures),
      .outstanding        (outstanding),
      .words_checked      (words_checked)
   );

   function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return SAMPLE_WIDTH'($urandom_range(32) - 16);
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   // random gap with valid low, then hold the word until it is taken
   task automatic send_frame(input logic [SAMPLE_WIDTH-1:0] l, input logic [SAMPLE_WIDTH-1:0] r,
                             input logic last);
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_left_sample  <= l;
      req_right_sample <= r;
      req_last_frame   <= last;
      do @(posedge clock); while (req_stall);
      frames_sent++;
   endtask

   // stop sending and wait until every due word has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [COEFF_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic edge_frames(input logic [LAYOUT_BITS-1:0] mode, input int first);
      drain();
      write_reg(CSR_LAYOUT_MODE, COEFF_WIDTH'(mode));
      csr_valid <= 1'b0;
      settings_run++;
      for (int k = 0; k < 3; k++) begin
         send_frame(EDGE_LEFT[(first + k) % 6], EDGE_RIGHT[(first + k) % 6], k == 2);
      end
   endtask

   initial begin
      logic [LAYOUT_BITS-1:0] mode;
      logic [COEFF_WIDTH-1:0] coeff;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // edge frames on every layout, coefficient left at its reset value
      edge_frames(LAYOUT_STEREO, 0);
      edge_frames(LAYOUT_QUAD, 3);
      edge_frames(LAYOUT_FIVE_ONE_B, 0);
      edge_frames(LAYOUT_FIVE_ONE_S, 3);
      edge_frames(LAYOUT_SEVEN_ONE, 0);
      for (int m = LAYOUT_SEVEN_ONE + 1; m < 2 ** LAYOUT_BITS; m++) begin
         edge_frames(m[LAYOUT_BITS-1:0], 3 * m);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               mode  = LAYOUT_FIVE_ONE_B;
               coeff = '1;
            end
            1: begin
               mode  = LAYOUT_SEVEN_ONE;
               coeff = '0;
            end
            2: begin
               mode  = LAYOUT_FIVE_ONE_S;
               coeff = COEFF_WIDTH'(1);
            end
            3: begin
               mode  = LAYOUT_SEVEN_ONE;
               coeff = 16'h8000;
            end
            default: begin
               mode  = LAYOUT_BITS'($urandom_range(2 ** LAYOUT_BITS - 1));
               coeff = COEFF_WIDTH'($urandom);
            end
         endcase
         drain();
         write_reg(CSR_LAYOUT_MODE, COEFF_WIDTH'(mode));
         write_reg(CSR_LP_GAIN, coeff);
         csr_valid <= 1'b0;
         calm      <= (phase == 5);
         settings_run++;
         for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
            // one pause mid-phase until the block has emptied
            if (phase == 7 && k == FRAMES_PER_PHASE / 2) drain();
            send_frame(pick_sample(), pick_sample(), $urandom_range(7) == 0);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d stereo frames over %0d layout/coefficient settings, all layout codes",
               frames_sent, settings_run);
      $display("included; %0d channel words compared under random idle and stall.",
               words_checked);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d words still due", cycle_count, outstanding);
      $display("Verification failed");
      $finish;
   end

endmodule
